// ----- hdl/tlbpt_pkg.sv -----
// tlbpt_pkg: widths, types and state codes shared by the TLB translator.
// No dependencies; imported by every tlbpt_* module.
`default_nettype none
package tlbpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int ADDR_W      = 16;
	localparam int OFFSET_W    = 8;
	localparam int PAGE_W      = 8;
	localparam int FRAME_W     = 8;
	localparam int PAGE_COUNT  = 1 << PAGE_W;
	localparam int CNT_W       = 32;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;

	typedef struct packed {
		logic   valid;
		page_t  page;
		frame_t frame;
	} tlbpt_entry_t;

	// lookup: read table frame at rd_page; commit: finish a TLB miss for page
	typedef struct packed {
		logic  lookup;
		page_t rd_page;
		logic  commit;
		page_t page;
	} tlbpt_pt_req_t;

	typedef struct packed {
		logic   fault;
		frame_t frame;
	} tlbpt_pt_rsp_t;

	typedef enum logic {
		TLBPT_IDLE,
		TLBPT_RESOLVE
	} tlbpt_state_t;

endpackage
`default_nettype wire

// ----- hdl/tlbpt_cell.sv -----
// tlbpt_cell: one TLB entry of the shifting FIFO chain, with its tag compare.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   shift_en,
	input  tlbpt_pkg::tlbpt_entry_t prev,
	input  tlbpt_pkg::page_t      lookup_page,
	output tlbpt_pkg::tlbpt_entry_t entry,
	output logic                  match
);
	import tlbpt_pkg::*;

	logic   valid_q;
	page_t  page_q;
	frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			page_q  <= prev.page;
			frame_q <= prev.frame;
		end
	end

	assign entry = '{valid: valid_q, page: page_q, frame: frame_q};
	assign match = valid_q && (page_q == lookup_page);

endmodule
`default_nettype wire

// ----- hdl/tlbpt_page_table.sv -----
// tlbpt_page_table: page-indexed frame store, per-page valid bits and the
// sequential frame allocator. Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_page_table (
	input  wire                  clk,
	input  wire                  arst_n,
	input  tlbpt_pkg::tlbpt_pt_req_t req,
	output tlbpt_pkg::tlbpt_pt_rsp_t rsp
);
	import tlbpt_pkg::*;

	frame_t                  mem [PAGE_COUNT];
	frame_t                  rd_q;
	logic [PAGE_COUNT-1:0]   valid_q;
	frame_t                  next_free_q;
	logic                    present;

	always_ff @(posedge clk) begin
		if (req.lookup) begin
			rd_q <= mem[req.rd_page];
		end
	end

	always_ff @(posedge clk) begin
		if (req.commit && !present) begin
			mem[req.page] <= next_free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			next_free_q <= '0;
		end else if (req.commit && !present) begin
			valid_q[req.page] <= 1'b1;
			next_free_q       <= next_free_q + 1'b1;
		end
	end

	assign present   = valid_q[req.page];
	assign rsp.fault = !present;
	assign rsp.frame = present ? rd_q : next_free_q;

endmodule
`default_nettype wire

// ----- hdl/tlb_page_table_translator_core.sv -----
// tlb_page_table_translator_core: TLB plus demand-paged table, one address per item.
// Depends on tlbpt_pkg, tlbpt_cell, tlbpt_page_table.
//
//  channel | handshake            | payload
//  req     | req_valid/req_stall  | virtual_address
//  rsp     | rsp_valid/rsp_stall  | physical_address, frame_number, tlb_hit,
//          |                      | demand_fault, hit_total, fault_total
//
// Per item, IDLE registers the address and reads the table store, and RESOLVE
// compares against the TLB chain and commits the update.
// The next item is taken while a result waits in the output register.
// Reset clears TLB and table valid bits, FIFO order, allocator and counters.
// A stalled result holds the resolve step until the output register frees.
`default_nettype none
module tlb_page_table_translator_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  wire  [tlbpt_pkg::ADDR_W-1:0]  virtual_address,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
	output tlbpt_pkg::frame_t             frame_number,
	output logic                          tlb_hit,
	output logic                          demand_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]   hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]   fault_total
);
	import tlbpt_pkg::*;

	tlbpt_state_t            state_q, state_d;
	logic [ADDR_W-1:0]       va_q;
	page_t                   page_s1;
	logic                    req_acc;
	logic                    out_free;
	logic                    done;
	logic                    miss_commit;
	tlbpt_entry_t            chain [TLB_ENTRIES+1];
	logic [TLB_ENTRIES-1:0]  match;
	logic                    hit;
	frame_t                  hit_frame;
	frame_t                  frame;
	tlbpt_pt_req_t           pt_req;
	tlbpt_pt_rsp_t           pt_rsp;
	logic [CNT_W-1:0]        hit_cnt_q, fault_cnt_q, hit_cnt_d, fault_cnt_d;
	logic                    rsp_valid_q;

	assign page_s1  = va_q[ADDR_W-1 -: PAGE_W];
	assign req_acc  = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			TLBPT_IDLE:    if (req_valid) state_d = TLBPT_RESOLVE;
			TLBPT_RESOLVE: if (out_free) state_d = TLBPT_IDLE;
			default:       state_d = TLBPT_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		done      = 1'b0;
		case (state_q)
			TLBPT_IDLE:    req_stall = 1'b0;
			TLBPT_RESOLVE: done = out_free;
			default:       req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TLBPT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			va_q <= virtual_address;
		end
	end

	// FIFO replacement: a new entry enters cell 0, the oldest drops off the end
	assign miss_commit = done && !hit;
	assign chain[0] = '{valid: 1'b1, page: page_s1, frame: pt_rsp.frame};

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		tlbpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (miss_commit),
			.prev       (chain[i]),
			.lookup_page(page_s1),
			.entry      (chain[i+1]),
			.match      (match[i])
		);
	end

	always_comb begin
		hit_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			hit_frame = hit_frame | (match[i] ? chain[i+1].frame : '0);
		end
	end
	assign hit = |match;

	assign pt_req = '{lookup: req_acc,
		rd_page: virtual_address[ADDR_W-1 -: PAGE_W],
		commit: miss_commit,
		page: page_s1};

	tlbpt_page_table u_pt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (pt_req),
		.rsp   (pt_rsp)
	);

	assign frame = hit ? hit_frame : pt_rsp.frame;

	always_comb begin
		hit_cnt_d   = hit_cnt_q;
		fault_cnt_d = fault_cnt_q;
		if (hit && !(&hit_cnt_q)) begin
			hit_cnt_d = hit_cnt_q + 1'b1;
		end
		if (!hit && pt_rsp.fault && !(&fault_cnt_q)) begin
			fault_cnt_d = fault_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (done) begin
				hit_cnt_q   <= hit_cnt_d;
				fault_cnt_q <= fault_cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			physical_address <= {frame, va_q[OFFSET_W-1:0]};
			frame_number     <= frame;
			tlb_hit          <= hit;
			demand_fault     <= !hit && pt_rsp.fault;
			hit_total        <= hit_cnt_d;
			fault_total      <= fault_cnt_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_tag_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == TLBPT_RESOLVE |-> $onehot0(match))
		else $error("duplicate TLB tag match");

	a_hit_xor_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(tlb_hit && demand_fault))
		else $error("result flagged as both hit and fault");

	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit && pt_rsp.fault && !(&fault_cnt_q)
		|=> fault_cnt_q == $past(fault_cnt_q) + 1'b1)
		else $error("fault counter did not advance on a fault");

	a_miss_fills: assert property (@(posedge clk) disable iff (!arst_n)
		miss_commit |=> chain[1].valid && chain[1].page == $past(page_s1))
		else $error("missed page not entered at head of TLB chain");

endmodule
`default_nettype wire

// ----- tb/tb_tlb_page_table_translator_core.sv -----
// tb_tlb_page_table_translator_core: self-checking bench for the TLB translator core.
// Predicts TLB lookup, demand paging and counters per item and checks every result.
// Depends on tlbpt_pkg and tlb_page_table_translator_core.
module tb_tlb_page_table_translator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tlbpt_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] phys;
		frame_t            frame;
		logic              hit;
		logic              fault;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  faults;
	} xlat_result_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [ADDR_W-1:0]   virtual_address;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [ADDR_W-1:0]   physical_address;
	frame_t              frame_number;
	logic                tlb_hit;
	logic                demand_fault;
	logic [CNT_W-1:0]    hit_total;
	logic [CNT_W-1:0]    fault_total;

	tlb_page_table_translator_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.virtual_address  (virtual_address),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.physical_address (physical_address),
		.frame_number     (frame_number),
		.tlb_hit          (tlb_hit),
		.demand_fault     (demand_fault),
		.hit_total        (hit_total),
		.fault_total      (fault_total)
	);

	// translation state mirror
	logic             tlb_ok [TLB_ENTRIES];
	page_t            tlb_pg [TLB_ENTRIES];
	frame_t           tlb_fr [TLB_ENTRIES];
	logic [3:0]       fifo_slot;
	logic             pt_ok [PAGE_COUNT];
	frame_t           pt_fr [PAGE_COUNT];
	frame_t           free_frame;
	logic [CNT_W-1:0] hit_count;
	logic [CNT_W-1:0] fault_count;

	xlat_result_t pending_translations[$];
	page_t        mapped_pages[$];
	page_t        recent_pages[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          mismatches;
	int          items_sent;
	int          tlb_hits_seen;
	int          faults_seen;
	int          table_hits_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic void clear_mirror();
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			tlb_ok[i] = 1'b0;
			tlb_pg[i] = '0;
			tlb_fr[i] = '0;
		end
		for (int i = 0; i < PAGE_COUNT; i++) begin
			pt_ok[i] = 1'b0;
			pt_fr[i] = '0;
		end
		fifo_slot   = '0;
		free_frame  = '0;
		hit_count   = '0;
		fault_count = '0;
	endfunction

	function automatic void translate_address(logic [ADDR_W-1:0] va);
		page_t        pg;
		frame_t       fr;
		logic         hit;
		logic         fault;
		xlat_result_t r;
		pg    = va[ADDR_W-1:OFFSET_W];
		fr    = '0;
		hit   = 1'b0;
		fault = 1'b0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!hit && tlb_ok[i] && tlb_pg[i] == pg) begin
				hit = 1'b1;
				fr  = tlb_fr[i];
			end
		end
		if (hit) begin
			if (hit_count != '1) hit_count++;
			tlb_hits_seen++;
		end else begin
			if (pt_ok[pg]) begin
				fr = pt_fr[pg];
				table_hits_seen++;
			end else begin
				fault = 1'b1;
				if (fault_count != '1) fault_count++;
				fr         = free_frame;
				free_frame = free_frame + 1'b1;
				pt_ok[pg]  = 1'b1;
				pt_fr[pg]  = fr;
				mapped_pages.push_back(pg);
				faults_seen++;
			end
			tlb_ok[fifo_slot] = 1'b1;
			tlb_pg[fifo_slot] = pg;
			tlb_fr[fifo_slot] = fr;
			fifo_slot         = fifo_slot + 1'b1;
		end
		r.phys   = {fr, va[OFFSET_W-1:0]};
		r.frame  = fr;
		r.hit    = hit;
		r.fault  = fault;
		r.hits   = hit_count;
		r.faults = fault_count;
		pending_translations.push_back(r);
		items_sent++;
	endfunction

	function automatic void compare_field(string field, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		xlat_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_translations.size() == 0) begin
				$error("result with no item outstanding: pa 0x%0h", physical_address);
				mismatches++;
			end else begin
				want = pending_translations.pop_front();
				compare_field("physical_address", want.phys, physical_address);
				compare_field("frame_number", want.frame, frame_number);
				compare_field("tlb_hit", want.hit, tlb_hit);
				compare_field("demand_fault", want.fault, demand_fault);
				compare_field("hit_total", want.hits, hit_total);
				compare_field("fault_total", want.faults, fault_total);
			end
		end
	end

	task automatic send_address(input logic [ADDR_W-1:0] va);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid       <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (req_stall);
		translate_address(va);
	endtask

	task automatic wait_for_drain();
		int guard;
		guard = 0;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_translations.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// extremes, same-page hits, FIFO eviction and table hit after eviction
	task automatic test_directed();
		logic [ADDR_W-1:0] seq[$];
		seq = '{16'h0000, 16'h00ff, 16'hffff, 16'hff00, 16'h8001, 16'h7ffe,
			16'h5555, 16'haaaa};
		for (int p = 8'h10; p <= 8'h1a; p++) seq.push_back({p[7:0], 8'h3c});
		seq.push_back(16'h0012);
		seq.push_back(16'h1a34);
		seq.push_back(16'h0000);
		foreach (seq[i]) send_address(seq[i]);
	endtask

	// mostly recently used pages, some older mapped pages, some fresh pages
	task automatic test_random_mix(input int count);
		page_t pg;
		int    pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45 && recent_pages.size() != 0)
				pg = recent_pages[$urandom_range(recent_pages.size() - 1)];
			else if (pick < 65 && mapped_pages.size() != 0)
				pg = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
			else
				pg = page_t'($urandom_range(PAGE_COUNT - 1));
			recent_pages.push_back(pg);
			if (recent_pages.size() > 24) void'(recent_pages.pop_front());
			send_address({pg, 8'($urandom_range(255))});
		end
	endtask

	// touch every page so the frame allocator runs out and wraps
	task automatic test_page_sweep();
		for (int p = 0; p < PAGE_COUNT; p++)
			send_address({8'(p), 8'($urandom_range(255))});
	endtask

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		virtual_address = '0;
		send_idle_pct   = 33;
		recv_idle_pct   = 55;
		mismatches      = 0;
		items_sent      = 0;
		tlb_hits_seen   = 0;
		faults_seen     = 0;
		table_hits_seen = 0;
		clear_mirror();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(600);
		wait_for_drain();

		send_idle_pct = 55;
		recv_idle_pct = 33;
		test_random_mix(600);
		wait_for_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_page_sweep();
		test_random_mix(170);
		wait_for_drain();

		if (pending_translations.size() != 0) begin
			$error("%0d results never arrived", pending_translations.size());
			mismatches++;
		end
		$display("translated %0d addresses: %0d TLB hits, %0d table hits, %0d faults",
			items_sent, tlb_hits_seen, table_hits_seen, faults_seen);
		$display("all %0d pages mapped, frame allocator wrapped, %0d mismatches",
			mapped_pages.size(), mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/tlbpt_pkg.sv
hdl/tlbpt_cell.sv
hdl/tlbpt_page_table.sv
hdl/tlb_page_table_translator_core.sv
tb/tb_tlb_page_table_translator_core.sv
